// File: rtl/core/pic_pkg.sv
// Shared types and constants of the platform interrupt controller.
package pic_pkg;

   // Widths of the item fields and stored words.
   localparam int PRIO_W     = 3;
   localparam int WORD_W     = 32;
   localparam int MASK_W     = 64;
   localparam int ID_W       = 6;
   localparam int FUNC_W     = 2;
   localparam int SEL_W      = 3;
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = FUNC_W + SEL_W;
   localparam int RSP_DATA_W = WORD_W;
   localparam int RSP_USER_W = 3;

   // Priority of a source that has never been written.
   localparam logic [PRIO_W-1:0] PRIO_RESET = 3'd1;

   // Function codes.
   localparam logic [FUNC_W-1:0] FUNC_EDGE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

   // Register selects.
   localparam logic [SEL_W-1:0] SEL_PRIO     = 3'd0;
   localparam logic [SEL_W-1:0] SEL_PEND_LO  = 3'd1;
   localparam logic [SEL_W-1:0] SEL_PEND_HI  = 3'd2;
   localparam logic [SEL_W-1:0] SEL_EN_LO    = 3'd3;
   localparam logic [SEL_W-1:0] SEL_EN_HI    = 3'd4;
   localparam logic [SEL_W-1:0] SEL_CLAIM    = 3'd5;
   localparam logic [SEL_W-1:0] SEL_THRESH   = 3'd6;

   // Control of the shared compare unit.
   typedef struct packed {
      logic start;   // clear the running best before a scan
      logic valid;   // an entry is presented this cycle
   } scan_ctl_type;

endpackage

// File: rtl/core/pic_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/pic_scan.sv
// Shared compare unit: keeps the best live source and counts sources above threshold.
module pic_scan #(
   parameter int ID_BITS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pic_pkg::scan_ctl_type         ctl,
   input  logic [ID_BITS-1:0]            idx,
   input  logic [pic_pkg::PRIO_W-1:0]    prio,
   input  logic                          live,
   input  logic [pic_pkg::WORD_W-1:0]    threshold,
   output logic [ID_BITS-1:0]            best_id,
   output logic [pic_pkg::PRIO_W-1:0]    best_prio,
   output logic [1:0]                    above_cnt
);

   logic [ID_BITS-1:0]         best_id_ff;
   logic [pic_pkg::PRIO_W-1:0] best_prio_ff;
   logic [1:0]                 above_ff;
   logic                       take_best;
   logic                       is_above;

   // A strictly higher priority wins, so ties keep the lower id seen first.
   assign take_best = ctl.valid && live && (prio > best_prio_ff);
   assign is_above  = ctl.valid && live &&
                      ({{(pic_pkg::WORD_W-pic_pkg::PRIO_W){1'b0}}, prio} > threshold);

   // Running best and a saturating count of sources above the threshold.
   always_ff @(posedge clock) begin
      if (reset || ctl.start) begin
         best_id_ff   <= '0;
         best_prio_ff <= '0;
         above_ff     <= '0;
      end else begin
         if (take_best) begin
            best_id_ff   <= idx;
            best_prio_ff <= prio;
         end
         if (is_above && above_ff != 2'd2) begin
            above_ff <= above_ff + 2'd1;
         end
      end
   end

   assign best_id   = best_id_ff;
   assign best_prio = best_prio_ff;
   assign above_cnt = above_ff;

endmodule

// File: rtl/core/platform_interrupt_controller.sv
// Top level of the single-target platform interrupt controller.
//
// Usage: each item on the req_ channel is a source edge, a register read or a
// register write; each item yields exactly one rsp_ item carrying read data and
// the interrupt line flags. Priorities live in a small RAM; the masks, the
// threshold and the line flag are flip-flops.
// Every item runs one scan over sources 1 to SOURCES-1 through a shared compare
// unit, one RAM read per cycle, which finds the claim winner and whether any
// source qualifies to raise the line. The RAM read port sets the pace.
// Flow: an item passes through the operation state, the scan states and a final
// compare state to the done state, where its result is loaded; the next item is
// taken in the cycle after the result is loaded, so items do not overlap.
// req_tready is high only while the block is idle. If the receiver stalls, the
// finished result waits in the output register and the next result is held
// back until that one is taken; the following item is still accepted.
// Reset clears masks, threshold and line; every priority reads as one until it
// is written, tracked by a valid bit per source, so no clearing pass is needed.
module platform_interrupt_controller #(
   parameter int SOURCES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request items.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // req_tdata: source_id [5:0], write_data [37:6], zero pad [39:38]
   input  logic [pic_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: func [1:0], reg_sel [4:2]
   input  logic [pic_pkg::REQ_USER_W-1:0]     req_tuser,
   // Response items.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // rsp_tdata: read_data [31:0]
   output logic [pic_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: line_level [0], line_raised [1], access_error [2]
   output logic [pic_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   localparam int IdW = $clog2(SOURCES);
   localparam logic [IdW-1:0] LastId = IdW'(SOURCES - 1);
   localparam logic [pic_pkg::ID_W:0] SrcCount = (pic_pkg::ID_W + 1)'(SOURCES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_OP,
      S_SCAN,
      S_LAST,
      S_DONE
   } state_type;

   state_type                      state_ff;
   logic [pic_pkg::FUNC_W-1:0]     func_ff;
   logic [pic_pkg::SEL_W-1:0]      sel_ff;
   logic [pic_pkg::ID_W-1:0]       id_ff;
   logic [pic_pkg::WORD_W-1:0]     wdata_ff;
   logic [pic_pkg::MASK_W-1:0]     pending_ff;
   logic [pic_pkg::MASK_W-1:0]     enable_ff;
   logic [pic_pkg::WORD_W-1:0]     thresh_ff;
   logic                           line_ff;
   logic [SOURCES-1:0]             prio_valid_ff;
   logic [IdW-1:0]                 scan_cnt_ff;
   logic                           cmp_valid_ff;
   logic [IdW-1:0]                 cmp_idx_ff;
   logic                           prd_ff;
   logic                           valid_q_ff;
   logic [pic_pkg::WORD_W-1:0]     rd_ff;
   logic                           err_ff;
   logic                           rsp_valid_ff;
   logic [pic_pkg::WORD_W-1:0]     rsp_data_ff;
   logic [pic_pkg::RSP_USER_W-1:0] rsp_user_ff;

   logic                           accept;
   logic                           fire;
   logic                           id_ok;
   logic                           is_claim;
   logic                           prio_wr;
   logic [IdW-1:0]                 ram_rd_addr;
   logic [pic_pkg::PRIO_W-1:0]     ram_q;
   logic [pic_pkg::PRIO_W-1:0]     prio_eff;
   logic [pic_pkg::MASK_W-1:0]     pend_en;
   logic [SOURCES-1:0]             live_src;
   pic_pkg::scan_ctl_type          scan_ctl;
   logic [IdW-1:0]                 best_id;
   logic [pic_pkg::PRIO_W-1:0]     best_prio;
   logic [1:0]                     above_cnt;
   logic                           best_above;
   logic                           claim_hit;
   logic                           raise;

   // Handshake and decode of the held item.
   assign accept   = req_tvalid && req_tready;
   assign fire     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign id_ok    = {1'b0, id_ff} < SrcCount;
   assign is_claim = (func_ff == pic_pkg::FUNC_READ) && (sel_ff == pic_pkg::SEL_CLAIM);
   assign prio_wr  = (state_ff == S_OP) && (func_ff == pic_pkg::FUNC_WRITE) &&
                     (sel_ff == pic_pkg::SEL_PRIO) && id_ok;

   // Priority RAM: item address in the operation cycle, scan counter otherwise.
   assign ram_rd_addr = (state_ff == S_OP) ? id_ff[IdW-1:0] : scan_cnt_ff;

   pic_ram #(
      .WIDTH(pic_pkg::PRIO_W),
      .DEPTH(SOURCES)
   ) u_prio_ram (
      .clock  (clock),
      .wr_en  (prio_wr),
      .wr_addr(id_ff[IdW-1:0]),
      .wr_data(wdata_ff[pic_pkg::PRIO_W-1:0]),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_q)
   );

   // An entry never written reads as the reset priority.
   assign prio_eff = valid_q_ff ? ram_q : pic_pkg::PRIO_RESET;
   assign pend_en  = pending_ff & enable_ff;
   assign live_src = pend_en[SOURCES-1:0];

   // Shared compare unit.
   assign scan_ctl.start = (state_ff == S_OP);
   assign scan_ctl.valid = cmp_valid_ff;

   pic_scan #(
      .ID_BITS(IdW)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .idx      (cmp_idx_ff),
      .prio     (prio_eff),
      .live     (live_src[cmp_idx_ff]),
      .threshold(thresh_ff),
      .best_id  (best_id),
      .best_prio(best_prio),
      .above_cnt(above_cnt)
   );

   // Line evaluation after a claim leaves out the claimed source.
   assign best_above = {{(pic_pkg::WORD_W-pic_pkg::PRIO_W){1'b0}}, best_prio} > thresh_ff;
   assign claim_hit  = is_claim && (best_id != '0) && best_above;
   assign raise      = !line_ff && ((above_cnt > 2'd1) || ((above_cnt == 2'd1) && !claim_hit));

   // Sequencer and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         func_ff       <= '0;
         sel_ff        <= '0;
         id_ff         <= '0;
         wdata_ff      <= '0;
         pending_ff    <= '0;
         enable_ff     <= '0;
         thresh_ff     <= '0;
         line_ff       <= 1'b0;
         prio_valid_ff <= '0;
         scan_cnt_ff   <= '0;
         cmp_valid_ff  <= 1'b0;
         cmp_idx_ff    <= '0;
         prd_ff        <= 1'b0;
         valid_q_ff    <= 1'b0;
         rd_ff         <= '0;
         err_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_data_ff   <= '0;
         rsp_user_ff   <= '0;
      end else begin
         valid_q_ff <= prio_valid_ff[ram_rd_addr];
         if (rsp_valid_ff && rsp_tready && !fire) begin
            rsp_valid_ff <= 1'b0;
         end
         // A priority read returns its data in the first scan cycle.
         if (prd_ff) begin
            rd_ff <= {{(pic_pkg::WORD_W-pic_pkg::PRIO_W){1'b0}}, prio_eff};
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  func_ff  <= req_tuser[pic_pkg::FUNC_W-1:0];
                  sel_ff   <= req_tuser[pic_pkg::REQ_USER_W-1:pic_pkg::FUNC_W];
                  id_ff    <= req_tdata[pic_pkg::ID_W-1:0];
                  wdata_ff <= req_tdata[pic_pkg::ID_W+pic_pkg::WORD_W-1:pic_pkg::ID_W];
                  rd_ff    <= '0;
                  err_ff   <= 1'b0;
                  state_ff <= S_OP;
               end
            end
            S_OP: begin
               // Apply the item to the stored state.
               cmp_valid_ff <= 1'b0;
               scan_cnt_ff  <= IdW'(1);
               state_ff     <= S_SCAN;
               case (func_ff)
                  pic_pkg::FUNC_EDGE: begin
                     if (id_ff == '0 || !id_ok) begin
                        err_ff <= 1'b1;
                     end else begin
                        pending_ff[id_ff] <= 1'b1;
                     end
                  end
                  pic_pkg::FUNC_READ: begin
                     case (sel_ff)
                        pic_pkg::SEL_PRIO: begin
                           if (id_ok) begin
                              prd_ff <= 1'b1;
                           end else begin
                              err_ff <= 1'b1;
                           end
                        end
                        pic_pkg::SEL_PEND_LO: rd_ff <= pending_ff[pic_pkg::WORD_W-1:0];
                        pic_pkg::SEL_PEND_HI: rd_ff <= pending_ff[pic_pkg::MASK_W-1:pic_pkg::WORD_W];
                        pic_pkg::SEL_EN_LO:   rd_ff <= enable_ff[pic_pkg::WORD_W-1:0];
                        pic_pkg::SEL_EN_HI:   rd_ff <= enable_ff[pic_pkg::MASK_W-1:pic_pkg::WORD_W];
                        pic_pkg::SEL_THRESH:  rd_ff <= thresh_ff;
                        default: ;
                     endcase
                  end
                  pic_pkg::FUNC_WRITE: begin
                     case (sel_ff)
                        pic_pkg::SEL_PRIO: begin
                           if (id_ok) begin
                              prio_valid_ff[id_ff[IdW-1:0]] <= 1'b1;
                           end else begin
                              err_ff <= 1'b1;
                           end
                        end
                        pic_pkg::SEL_PEND_LO, pic_pkg::SEL_PEND_HI: err_ff <= 1'b1;
                        pic_pkg::SEL_EN_LO: enable_ff[pic_pkg::WORD_W-1:0] <= wdata_ff;
                        pic_pkg::SEL_EN_HI:
                           enable_ff[pic_pkg::MASK_W-1:pic_pkg::WORD_W] <= wdata_ff;
                        pic_pkg::SEL_CLAIM:  line_ff   <= 1'b0;
                        pic_pkg::SEL_THRESH: thresh_ff <= wdata_ff;
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
            S_SCAN: begin
               // One source per cycle; its priority arrives next cycle.
               prd_ff       <= 1'b0;
               cmp_valid_ff <= 1'b1;
               cmp_idx_ff   <= scan_cnt_ff;
               if (scan_cnt_ff == LastId) begin
                  state_ff <= S_LAST;
               end else begin
                  scan_cnt_ff <= scan_cnt_ff + IdW'(1);
               end
            end
            S_LAST: begin
               cmp_valid_ff <= 1'b0;
               state_ff     <= S_DONE;
            end
            S_DONE: begin
               if (fire) begin
                  if (is_claim) begin
                     pending_ff <= pending_ff & ~(pic_pkg::MASK_W'(1) << best_id);
                  end
                  if (raise) begin
                     line_ff <= 1'b1;
                  end
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= is_claim ? {{(pic_pkg::WORD_W-IdW){1'b0}}, best_id} : rd_ff;
                  rsp_user_ff  <= {err_ff, raise, line_ff || raise};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A claimed source must have been pending and enabled.
   a_claim_live: assert property (@(posedge clock) disable iff (reset)
      (fire && is_claim && best_id != '0) |-> live_src[best_id])
      else $error("claimed source is not pending and enabled");

   // The scan never visits source zero.
   a_scan_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_cnt_ff != '0))
      else $error("scan counter reached source zero");

   // An accepted item always starts with its operation cycle.
   a_accept_op: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_OP))
      else $error("accepted item did not enter the operation cycle");

   // A raise leaves the line high.
   a_raise_line: assert property (@(posedge clock) disable iff (reset)
      (fire && raise) |=> line_ff)
      else $error("line not high after a raise");

   // The compare stage runs only while a scan is in flight.
   a_cmp_window: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> (state_ff == S_SCAN || state_ff == S_LAST))
      else $error("compare active outside a scan");

endmodule
